// ===== design/event_mask_time_consistency_filter_unit_defines.svh =====
// Assertion macros used by the filter port checker.
`ifndef EVENT_MASK_TIME_CONSISTENCY_FILTER_UNIT_DEFINES_SVH
`define EVENT_MASK_TIME_CONSISTENCY_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EMTCF_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EMTCF_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/emtcf_pkg.sv =====
// Types and constants of the event mask time consistency filter.
package emtcf_pkg;

	localparam int COORD_W   = 10;
	localparam int DIM_W     = 11;
	localparam int THR_W     = 32;
	localparam int PTIME_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int ROW_LIMIT = 1024;
	localparam int SLOTS     = 3;
	localparam int CNT_W     = 2;
	localparam int QDEPTH    = 4;
	localparam int QAW       = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_THRESHOLD = 2'd2;

	localparam logic [DIM_W-1:0] DIM_MIN             = 11'd3;
	localparam logic [DIM_W-1:0] RST_FRAME_WIDTH     = 11'd640;
	localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT    = 11'd480;
	localparam logic [THR_W-1:0] RST_TIME_THRESHOLD  = 32'd7000;

	typedef struct packed {
		logic               frame_start;
		logic               pixel_set;
		logic [PTIME_W-1:0] pixel_time;
	} pix_in_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_row;
		logic [COORD_W-1:0] out_col;
		logic               out_set;
		logic               last;
	} pix_out_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               set;
	} res_t;

	// All results caused by one input word, in emission order.
	typedef struct packed {
		res_t [SLOTS-1:0] slots;
		logic [CNT_W-1:0] cnt;
	} q_entry_t;

endpackage

// ===== design/event_mask_time_consistency_filter_unit.sv =====
// Top level of the event mask 3x3 time consistency filter.
//
//  channel | handshake            | word
//  in      | in_valid / in_ready  | pix_in_t: frame_start, pixel_set, pixel_time
//  out     | out_valid / out_ready| pix_out_t: out_row, out_col, out_set, last
//  cfg     | cfg_we               | cfg_idx selects register, cfg_data value
//
// One input word per cycle while in_ready is high; output gives one word per cycle
// while out_ready is high, so words that cause two or three results (row ends, last row)
// give that many output words. Stage 1 loads at a word's accept edge, then stage 2,
// queue and output register follow; a full queue or low out_ready can stall them.
// Reset clears counters, window and queue, sets config defaults; line buffers stay.
// With out_ready low the four-entry queue fills, then the front holds and in_ready drops.
module event_mask_time_consistency_filter_unit import emtcf_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pix_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pix_out_t              out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [DIM_W-1:0] WLIM =
		DIM_W'((MAX_WIDTH < ROW_LIMIT) ? MAX_WIDTH : ROW_LIMIT);
	localparam logic [DIM_W-1:0] HLIM = DIM_W'(ROW_LIMIT);

	logic [DIM_W-1:0] frame_width_q, frame_height_q;
	logic [THR_W-1:0] time_threshold_q;
	logic [DIM_W-1:0] width_use, height_use;

	logic     q_full, push, pop, nempty;
	q_entry_t push_entry, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= RST_FRAME_WIDTH;
			frame_height_q   <= RST_FRAME_HEIGHT;
			time_threshold_q <= RST_TIME_THRESHOLD;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[DIM_W-1:0];
				end
				CFG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[DIM_W-1:0];
				end
				CFG_TIME_THRESHOLD: begin
					time_threshold_q <= cfg_data[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp the frame size to what the line buffers and counters hold.
	always_comb begin
		priority if (frame_width_q < DIM_MIN) begin
			width_use = DIM_MIN;
		end else if (frame_width_q > WLIM) begin
			width_use = WLIM;
		end else begin
			width_use = frame_width_q;
		end
		priority if (frame_height_q < DIM_MIN) begin
			height_use = DIM_MIN;
		end else if (frame_height_q > HLIM) begin
			height_use = HLIM;
		end else begin
			height_use = frame_height_q;
		end
	end

	emtcf_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.width_use  (width_use),
		.height_use (height_use),
		.threshold  (time_threshold_q),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	emtcf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.nempty     (nempty)
	);

	emtcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.nempty    (nempty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== design/emtcf_front.sv =====
// Front end: position counters, line buffers, 3x3 window, filter and result classification.
module emtcf_front import emtcf_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int TIME_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pix_in_t          in_data,
	input  logic [DIM_W-1:0] width_use,
	input  logic [DIM_W-1:0] height_use,
	input  logic [THR_W-1:0] threshold,
	input  logic             q_full,
	output logic             push,
	output q_entry_t         push_entry
);

	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int WORD_W = TIME_BITS + 1;
	localparam int CW     = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;

	typedef struct packed {
		logic own;
		logic behind;
		logic at_end;
		logic col_one;
	} flags_t;

	logic [COORD_W-1:0] row_q, col_q;
	logic [DIM_W-1:0]   r_a, c_a, c_inc, r_inc;
	logic [COORD_W-1:0] r0, c0, row_nx, col_nx;
	flags_t             fl0;
	logic               acc, en;
	logic [AW-1:0]      addr;
	logic [WORD_W-1:0]  wword;

	logic [WORD_W-1:0]  bank0 [MAX_WIDTH];
	logic [WORD_W-1:0]  bank1 [MAX_WIDTH];
	logic [WORD_W-1:0]  rd0_q, rd1_q;

	logic                 v_s1;
	logic                 px_set_s1;
	logic [TIME_BITS-1:0] px_t_s1;
	logic [COORD_W-1:0]   r_s1, c_s1;
	flags_t               fl_s1;
	logic [WORD_W-1:0]    above2, above1;

	logic                 win_set_q [3][3];
	logic [TIME_BITS-1:0] win_t_q [3][3];

	logic               v_s2;
	logic               px_set_s2;
	logic [COORD_W-1:0] r_s2, c_s2;
	flags_t             fl_s2;

	logic               kill, filt;
	res_t               rb, re, ro;
	q_entry_t           ent;

	// Position of this word, then of the next one.
	always_comb begin
		r_a = {1'b0, row_q};
		c_a = {1'b0, col_q};
		if (in_data.frame_start) begin
			r_a = '0;
			c_a = '0;
		end else if (c_a >= width_use) begin
			c_a = '0;
			r_a = r_a + DIM_W'(1);
		end
		if (r_a >= height_use) begin
			r_a = '0;
		end
		r0 = r_a[COORD_W-1:0];
		c0 = c_a[COORD_W-1:0];
		c_inc = c_a + DIM_W'(1);
		r_inc = r_a + DIM_W'(1);
		if (c_inc >= width_use) begin
			col_nx = '0;
			row_nx = (r_inc >= height_use) ? '0 : r_inc[COORD_W-1:0];
		end else begin
			col_nx = c_inc[COORD_W-1:0];
			row_nx = r0;
		end
		fl0.own     = (r0 == '0) || (r_a == height_use - DIM_W'(1));
		fl0.behind  = (r0 >= COORD_W'(2)) && (c0 >= COORD_W'(1));
		fl0.at_end  = (c_a == width_use - DIM_W'(1));
		fl0.col_one = (c0 == COORD_W'(1));
	end

	assign acc   = in_valid && en;
	assign addr  = AW'(c0);
	assign wword = {in_data.pixel_set, TIME_BITS'(in_data.pixel_time)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc) begin
			row_q <= row_nx;
			col_q <= col_nx;
		end
	end

	// Line buffers: read both rows at this column, overwrite the older one.
	always_ff @(posedge clk) begin
		if (acc) begin
			rd0_q <= bank0[addr];
			rd1_q <= bank1[addr];
			if (!r0[0]) begin
				bank0[addr] <= wword;
			end else begin
				bank1[addr] <= wword;
			end
		end
	end

	// Stage 1: word with its line buffer reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_set_s1 <= in_data.pixel_set;
			px_t_s1   <= TIME_BITS'(in_data.pixel_time);
			r_s1      <= r0;
			c_s1      <= c0;
			fl_s1     <= fl0;
		end
	end

	assign above2 = r_s1[0] ? rd1_q : rd0_q;
	assign above1 = r_s1[0] ? rd0_q : rd1_q;

	// Shift the window one column as the word moves to stage 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_set_q[i][j] <= 1'b0;
					win_t_q[i][j]   <= '0;
				end
			end
		end else if (en && v_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_set_q[i][0] <= win_set_q[i][1];
				win_t_q[i][0]   <= win_t_q[i][1];
				win_set_q[i][1] <= win_set_q[i][2];
				win_t_q[i][1]   <= win_t_q[i][2];
			end
			win_set_q[0][2] <= above2[WORD_W-1];
			win_t_q[0][2]   <= above2[TIME_BITS-1:0];
			win_set_q[1][2] <= above1[WORD_W-1];
			win_t_q[1][2]   <= above1[TIME_BITS-1:0];
			win_set_q[2][2] <= px_set_s1;
			win_t_q[2][2]   <= px_t_s1;
		end
	end

	// Stage 2: filter the window centre and gather the results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			px_set_s2 <= px_set_s1;
			r_s2      <= r_s1;
			c_s2      <= c_s1;
			fl_s2     <= fl_s1;
		end
	end

	always_comb begin
		logic [TIME_BITS-1:0] d;
		kill = 1'b0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				d = (win_t_q[1][1] > win_t_q[i][j]) ? (win_t_q[1][1] - win_t_q[i][j])
					: (win_t_q[i][j] - win_t_q[1][1]);
				if (!(i == 1 && j == 1) && win_set_q[i][j] && (CW'(d) >= CW'(threshold))) begin
					kill = 1'b1;
				end
			end
		end
		filt = win_set_q[1][1] && !kill;
	end

	always_comb begin
		rb.row = r_s2 - COORD_W'(1);
		rb.col = c_s2 - COORD_W'(1);
		rb.set = fl_s2.col_one ? win_set_q[1][1] : filt;
		re.row = r_s2 - COORD_W'(1);
		re.col = c_s2;
		re.set = win_set_q[1][2];
		ro.row = r_s2;
		ro.col = c_s2;
		ro.set = px_set_s2;
		ent = '0;
		if (fl_s2.behind) begin
			ent.slots[0] = rb;
			if (fl_s2.at_end) begin
				ent.slots[1] = re;
				ent.slots[2] = ro;
				ent.cnt = fl_s2.own ? CNT_W'(3) : CNT_W'(2);
			end else begin
				ent.slots[1] = ro;
				ent.cnt = fl_s2.own ? CNT_W'(2) : CNT_W'(1);
			end
		end else begin
			ent.slots[0] = ro;
			ent.cnt = fl_s2.own ? CNT_W'(1) : CNT_W'(0);
		end
	end

	// Hold the whole front while stage 2 has results and the queue is full.
	assign en         = !(v_s2 && (ent.cnt != '0) && q_full);
	assign in_ready   = en;
	assign push       = v_s2 && (ent.cnt != '0) && !q_full;
	assign push_entry = ent;

endmodule

// ===== design/emtcf_queue.sv =====
// Short queue of per-word result groups between front and back.
module emtcf_queue import emtcf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     full,
	input  logic     pop,
	output q_entry_t head,
	output logic     nempty
);

	q_entry_t         mem_q [QDEPTH];
	logic [QAW-1:0]   wp_q, rp_q;
	logic [QAW:0]     cnt_q;

	assign full   = (cnt_q == (QAW+1)'(QDEPTH));
	assign nempty = (cnt_q != '0);
	assign head   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + QAW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QAW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QAW+1)'(1);
			end
		end
	end

endmodule

// ===== design/emtcf_back.sv =====
// Back end: unpacks each result group into single output words.
module emtcf_back import emtcf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     nempty,
	input  q_entry_t head,
	output logic     pop,
	output logic     out_valid,
	input  logic     out_ready,
	output pix_out_t out_data
);

	logic [CNT_W-1:0] k_q;
	logic             out_valid_q;
	pix_out_t         out_q;
	logic             load, is_last;

	assign load      = nempty && (!out_valid_q || out_ready);
	assign is_last   = (k_q == head.cnt - CNT_W'(1));
	assign pop       = load && is_last;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			k_q         <= is_last ? '0 : k_q + CNT_W'(1);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_row <= head.slots[k_q].row;
			out_q.out_col <= head.slots[k_q].col;
			out_q.out_set <= head.slots[k_q].set;
			out_q.last    <= is_last;
		end
	end

endmodule

// ===== design/emtcf_checker.sv =====
// Port checker for the filter top level, with its bind.
`include "event_mask_time_consistency_filter_unit_defines.svh"

module emtcf_checker import emtcf_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     out_valid,
	input logic     out_ready,
	input pix_out_t out_data
);

	`EMTCF_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed while stalled")
	`EMTCF_ASSERT_NXT(a_group_cont, clk, arst_n, out_valid && out_ready && !out_data.last, out_valid, "result group broken up")
	`EMTCF_ASSERT_NXT(a_group_row, clk, arst_n, out_valid && out_ready && !out_data.last, (out_data.out_row == $past(out_data.out_row)) || (out_data.out_row == $past(out_data.out_row) + 10'd1), "row jump inside a result group")
	`EMTCF_ASSERT_NXT(a_group_col, clk, arst_n, out_valid && out_ready && !out_data.last, (out_data.out_col == $past(out_data.out_col)) || (out_data.out_col == $past(out_data.out_col) + 10'd1), "column jump inside a result group")

endmodule

bind event_mask_time_consistency_filter_unit emtcf_checker u_chk (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the event mask 3x3 time consistency filter.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import emtcf_pkg::*;

	localparam int LINE_DEPTH = 1024;
	localparam int DIM_CAP = 1024;
	localparam int RAND_WORDS = 470;
	localparam int SETTLE_CYCLES = 12;
	localparam int RUN_LIMIT = 400000;

	typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_BUSY} sink_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	pix_in_t               in_data;
	logic                  out_valid;
	logic                  out_ready;
	pix_out_t              out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	// filter shadow: line buffers, 3x3 window, position and registers
	logic               line_set  [2*LINE_DEPTH];
	logic [PTIME_W-1:0] line_time [2*LINE_DEPTH];
	bit                 line_seen [2*LINE_DEPTH];
	logic               win_set   [3][3];
	logic [PTIME_W-1:0] win_time  [3][3];
	int unsigned        row_pos;
	int unsigned        col_pos;
	logic [DIM_W-1:0]   width_reg;
	logic [DIM_W-1:0]   height_reg;
	logic [THR_W-1:0]   thr_reg;

	pix_in_t    pending_words [$];
	pix_out_t   due_pixels [$];
	bit         word_taken;
	int         burst_left;
	int         gap_left;
	sink_mode_t sink_mode;
	int         sink_left;
	int         mismatch_count;
	int         cycle_count;

	event_mask_time_consistency_filter_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
		if (v < DIM_MIN) return 32'(DIM_MIN);
		if (v > DIM_CAP) return DIM_CAP;
		return 32'(v);
	endfunction

	function automatic logic centre_kept();
		logic               keep;
		logic [PTIME_W-1:0] diff;
		keep = win_set[1][1];
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (!(i == 1 && j == 1) && win_set[i][j]) begin
					diff = (win_time[1][1] > win_time[i][j]) ? win_time[1][1] - win_time[i][j]
						: win_time[i][j] - win_time[1][1];
					if (diff >= thr_reg) keep = 1'b0;
				end
			end
		end
		return keep;
	endfunction

	function automatic pix_out_t make_result(input int unsigned r, input int unsigned c,
			input logic s);
		pix_out_t p;
		p.out_row = r[COORD_W-1:0];
		p.out_col = c[COORD_W-1:0];
		p.out_set = s;
		p.last = 1'b0;
		return p;
	endfunction

	// True when every column below w of both line buffers holds a written pixel.
	function automatic bit lines_ready(input int unsigned w);
		for (int k = 0; k < w; k++)
			if (!line_seen[k] || !line_seen[LINE_DEPTH + k]) return 1'b0;
		return 1'b1;
	endfunction

	// Advance the shadow filter by one input word and queue the pixels it emits.
	task automatic filter_pixel(input pix_in_t px);
		int unsigned w, h, r, c, cur, oth;
		pix_out_t    res [$];
		pix_out_t    tail;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		r = row_pos;
		c = col_pos;
		if (px.frame_start) begin
			r = 0;
			c = 0;
		end else if (c >= w) begin
			c = 0;
			r = r + 1;
		end
		if (r >= h) r = 0;
		cur = (r % 2) * LINE_DEPTH + c;
		oth = ((r + 1) % 2) * LINE_DEPTH + c;
		for (int i = 0; i < 3; i++) begin
			win_set[i][0] = win_set[i][1];
			win_time[i][0] = win_time[i][1];
			win_set[i][1] = win_set[i][2];
			win_time[i][1] = win_time[i][2];
		end
		win_set[0][2] = line_set[cur];
		win_time[0][2] = line_time[cur];
		win_set[1][2] = line_set[oth];
		win_time[1][2] = line_time[oth];
		win_set[2][2] = px.pixel_set;
		win_time[2][2] = px.pixel_time;
		line_set[cur] = px.pixel_set;
		line_time[cur] = px.pixel_time;
		line_seen[cur] = 1'b1;
		if (r == 0) begin
			res = {res, make_result(r, c, px.pixel_set)};
		end else begin
			if (r >= 2 && c >= 1) begin
				if (c == 1) res = {res, make_result(r - 1, 0, win_set[1][1])};
				else res = {res, make_result(r - 1, c - 1, centre_kept())};
				if (c == w - 1) res = {res, make_result(r - 1, c, win_set[1][2])};
			end
			if (r == h - 1) res = {res, make_result(r, c, px.pixel_set)};
		end
		if (res.size() > 0) begin
			tail = res[res.size() - 1];
			tail.last = 1'b1;
			res[res.size() - 1] = tail;
		end
		foreach (res[k]) due_pixels = {due_pixels, res[k]};
		c = c + 1;
		if (c >= w) begin
			c = 0;
			r = (r + 1 >= h) ? 0 : r + 1;
		end
		row_pos = r % 1024;
		col_pos = c % 1024;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FRAME_WIDTH: width_reg = val[DIM_W-1:0];
			CFG_FRAME_HEIGHT: height_reg = val[DIM_W-1:0];
			CFG_TIME_THRESHOLD: thr_reg = val[THR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_word(input logic fs, input logic s, input logic [PTIME_W-1:0] t);
		pix_in_t word;
		word.frame_start = fs;
		word.pixel_set = s;
		word.pixel_time = t;
		pending_words = {pending_words, word};
	endtask

	function automatic logic [PTIME_W-1:0] pick_time(input logic [PTIME_W-1:0] base,
			input logic [PTIME_W-1:0] span);
		if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? '1 : '0;
		if (span == 0) return $urandom();
		return base + $urandom_range(0, span);
	endfunction

	// Wait until every word is taken and every pixel is out, then let the pipe drain.
	task automatic settle();
		while (pending_words.size() != 0 || in_valid) @(posedge clk);
		while (due_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender: bursts of words with idle gaps between them
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || word_taken) begin
			word_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				in_data <= pending_words.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 16);
					gap_left = $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switches among open, coin-flip, sparse and busy modes
	always @(negedge clk) begin
		if (sink_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 3));
			sink_left = $urandom_range(20, 150);
		end else begin
			sink_left--;
		end
		case (sink_mode)
			SINK_OPEN: out_ready <= 1'b1;
			SINK_COIN: out_ready <= $urandom_range(0, 1);
			SINK_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		pix_out_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				filter_pixel(in_data);
				word_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (due_pixels.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("cycle %0d: unexpected pixel row %0d col %0d set %0b last %0b",
							cycle_count, out_data.out_row, out_data.out_col, out_data.out_set,
							out_data.last);
				end else begin
					want = due_pixels.pop_front();
					if (out_data.out_row !== want.out_row || out_data.out_col !== want.out_col
							|| out_data.out_set !== want.out_set || out_data.last !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("cycle %0d: expected row %0d col %0d set %0b last %0b,",
								cycle_count, want.out_row, want.out_col, want.out_set, want.last);
							$display("  got row %0d col %0d set %0b last %0b",
								out_data.out_row, out_data.out_col, out_data.out_set,
								out_data.last);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] wv, hv, tv;
		logic [PTIME_W-1:0]    base, span;
		int unsigned           w, h, n, pick, frame_pos, density;
		int                    sent;
		bit                    carry_on, fs;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_FRAME_WIDTH;
		cfg_data = '0;
		word_taken = 1'b0;
		burst_left = 0;
		gap_left = 0;
		sink_mode = SINK_OPEN;
		sink_left = 0;
		mismatch_count = 0;
		cycle_count = 0;
		sent = 0;
		for (int k = 0; k < 2 * LINE_DEPTH; k++) begin
			line_set[k] = 1'b0;
			line_time[k] = '0;
			line_seen[k] = 1'b0;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				win_set[i][j] = 1'b0;
				win_time[i][j] = '0;
			end
		end
		row_pos = 0;
		col_pos = 0;
		width_reg = RST_FRAME_WIDTH;
		height_reg = RST_FRAME_HEIGHT;
		thr_reg = RST_TIME_THRESHOLD;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// dimensions below the minimum, largest threshold: only a full-scale gap clears
		write_reg(CFG_FRAME_WIDTH, 32'd2);
		write_reg(CFG_FRAME_HEIGHT, 32'd0);
		write_reg(CFG_TIME_THRESHOLD, '1);
		push_word(1'b1, 1'b1, 32'hFFFF_FFFF);
		push_word(1'b0, 1'b1, 32'd5);
		push_word(1'b0, 1'b0, 32'd0);
		push_word(1'b0, 1'b0, 32'd7);
		push_word(1'b0, 1'b1, 32'd0);
		push_word(1'b0, 1'b1, 32'hFFFF_FFFF);
		push_word(1'b0, 1'b1, 32'd0);
		push_word(1'b0, 1'b0, 32'd0);
		push_word(1'b0, 1'b1, 32'hFFFF_FFFE);
		settle();

		// zero threshold: a lone set centre survives, one with a set neighbour drops
		write_reg(CFG_FRAME_WIDTH, 32'd5);
		write_reg(CFG_FRAME_HEIGHT, 32'd3);
		write_reg(CFG_TIME_THRESHOLD, 32'd0);
		for (int k = 0; k < 15; k++)
			push_word(k == 0, (k == 4) || (k == 6) || (k == 8), 32'h5A5A_A5A5);
		settle();

		while (sent < RAND_WORDS) begin
			pick = $urandom_range(0, 19);
			if (pick < 13) wv = $urandom_range(3, 9);
			else if (pick < 15) wv = $urandom_range(0, 2);
			else if (pick == 15) wv = 32'd1024;
			else if (pick == 16) wv = 32'd2047;
			else if (pick == 17) wv = $urandom_range(1025, 2046);
			else wv = $urandom_range(10, 24);
			if ($urandom_range(0, 7) == 0)
				wv[CFG_DATA_W-1:DIM_W] = (CFG_DATA_W-DIM_W)'($urandom());
			pick = $urandom_range(0, 19);
			if (pick < 13) hv = $urandom_range(3, 7);
			else if (pick == 13) hv = $urandom_range(0, 2);
			else if (pick == 14) hv = 32'd1024;
			else if (pick == 15) hv = 32'd2047;
			else hv = $urandom_range(8, 20);
			if ($urandom_range(0, 7) == 0)
				hv[CFG_DATA_W-1:DIM_W] = (CFG_DATA_W-DIM_W)'($urandom());
			pick = $urandom_range(0, 19);
			if (pick < 4) tv = '0;
			else if (pick < 6) tv = '1;
			else if (pick < 14) tv = $urandom_range(1, 400);
			else tv = $urandom();
			write_reg(CFG_FRAME_WIDTH, wv);
			write_reg(CFG_FRAME_HEIGHT, hv);
			write_reg(CFG_TIME_THRESHOLD, tv);
			w = clamp_dim(width_reg);
			h = clamp_dim(height_reg);
			// resume the running frame only at frame start or where the line buffers cover the new width
			carry_on = ($urandom_range(0, 4) == 0)
				&& ((row_pos == 0 && col_pos == 0) || lines_ready(w));
			if (w * h <= 64) n = $urandom_range(1, 3) * w * h + $urandom_range(0, w);
			else n = $urandom_range(25, 70);
			density = $urandom_range(15, 90);
			base = $urandom();
			if (thr_reg == 0) span = 64;
			else if (thr_reg > 32'h4000_0000) span = 0;
			else span = thr_reg * 2;
			frame_pos = carry_on ? 1 : 0;
			for (int k = 0; k < n; k++) begin
				if (k == 0) fs = !carry_on;
				else if (frame_pos % (w * h) == 0) fs = ($urandom_range(0, 3) != 0);
				else fs = ($urandom_range(0, 39) == 0);
				if (fs) frame_pos = 0;
				push_word(fs, $urandom_range(0, 99) < density, pick_time(base, span));
				frame_pos++;
			end
			sent += n;
			settle();
		end

		if (mismatch_count == 0 && due_pixels.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
